FILE: sv/dlcfw_pkg.sv
// ----------------------------------------------------------------------------
// dlcfw_pkg
// Types and constants shared by the dual-link command failover watchdog.
// ----------------------------------------------------------------------------
package dlcfw_pkg;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned LATENCY_W  = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [LATENCY_W-1:0] LATENCY_RESET = LATENCY_W'(100);
    localparam logic [TIME_W-1:0]    PERIOD_RESET  = TIME_W'(1000);

    localparam logic [CFG_INDEX_W-1:0] CFG_ALLOWED_LATENCY = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_WORST_PERIOD    = CFG_INDEX_W'(1);

    typedef enum logic [1:0] {
        SEL_PRIMARY = 2'd0,
        SEL_AUX     = 2'd1,
        SEL_COAST   = 2'd2
    } source_sel_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              reinit_button;
        logic              pri_speed_seen;
        logic              pri_torque_seen;
        logic [TIME_W-1:0] pri_speed_stamp;
        logic [TIME_W-1:0] pri_torque_stamp;
        logic              aux_speed_seen;
        logic              aux_torque_seen;
        logic [TIME_W-1:0] aux_speed_stamp;
        logic [TIME_W-1:0] aux_torque_stamp;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        source_select;
        logic              running;
        logic              pri_failed;
        logic              aux_failed;
        logic [TIME_W-1:0] pri_worst_ms;
        logic [TIME_W-1:0] aux_worst_ms;
    } out_word_t;

    typedef struct packed {
        logic              failed;
        logic [TIME_W-1:0] worst_age;
    } link_status_t;

endpackage

FILE: sv/dual_link_command_failover_watchdog.sv
// ----------------------------------------------------------------------------
// dual_link_command_failover_watchdog
// Per-tick timing watchdog for a primary and an auxiliary command link.
// ----------------------------------------------------------------------------
// Each accepted word is one control tick. It is captured in an input register,
// evaluated in a single combinational pass (link timing checks, run flag,
// source selection, period and worst-age update) and written to a result
// register, so a word can be accepted every clock cycle while the output side
// keeps taking results, and the result is presented on the output from that
// register. The result register decouples the sides: a new word is taken
// while a finished result waits. Configuration writes must only happen while
// no tick is in flight.
module dual_link_command_failover_watchdog (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  dlcfw_pkg::in_word_t               s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output dlcfw_pkg::out_word_t              m_data,
    input  logic                              cfg_wr_en,
    input  logic [dlcfw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dlcfw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic                            in_vld_reg;
    dlcfw_pkg::in_word_t             in_reg;
    logic                            out_vld_reg;
    dlcfw_pkg::out_word_t            out_reg;
    logic                            advance;
    logic [dlcfw_pkg::LATENCY_W-1:0] latency_reg;
    logic [dlcfw_pkg::TIME_W-1:0]    period_reg;
    dlcfw_pkg::link_status_t         pri_status;
    dlcfw_pkg::link_status_t         aux_status;
    dlcfw_pkg::out_word_t            result;

    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latency_reg <= dlcfw_pkg::LATENCY_RESET;
            period_reg  <= dlcfw_pkg::PERIOD_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == dlcfw_pkg::CFG_ALLOWED_LATENCY) begin
                latency_reg <= cfg_wdata[dlcfw_pkg::LATENCY_W-1:0];
            end else if (cfg_index == dlcfw_pkg::CFG_WORST_PERIOD) begin
                period_reg <= cfg_wdata[dlcfw_pkg::TIME_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    dlcfw_link_eval u_pri_eval (
        .now_ms          (in_reg.now_ms),
        .speed_seen      (in_reg.pri_speed_seen),
        .torque_seen     (in_reg.pri_torque_seen),
        .speed_stamp     (in_reg.pri_speed_stamp),
        .torque_stamp    (in_reg.pri_torque_stamp),
        .age_limit       (latency_reg),
        .status          (pri_status)
    );

    dlcfw_link_eval u_aux_eval (
        .now_ms          (in_reg.now_ms),
        .speed_seen      (in_reg.aux_speed_seen),
        .torque_seen     (in_reg.aux_torque_seen),
        .speed_stamp     (in_reg.aux_speed_stamp),
        .torque_stamp    (in_reg.aux_torque_stamp),
        .age_limit       (latency_reg),
        .status          (aux_status)
    );

    dlcfw_supervisor u_supervisor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .now_ms        (in_reg.now_ms),
        .reinit_button (in_reg.reinit_button),
        .pri_status    (pri_status),
        .aux_status    (aux_status),
        .worst_period  (period_reg),
        .result        (result)
    );

endmodule

FILE: sv/dlcfw_link_eval.sv
// ----------------------------------------------------------------------------
// dlcfw_link_eval
// Timing check of one command link: failure flag and worst unsigned age.
// ----------------------------------------------------------------------------
module dlcfw_link_eval (
    input  logic [dlcfw_pkg::TIME_W-1:0]    now_ms,
    input  logic                            speed_seen,
    input  logic                            torque_seen,
    input  logic [dlcfw_pkg::TIME_W-1:0]    speed_stamp,
    input  logic [dlcfw_pkg::TIME_W-1:0]    torque_stamp,
    input  logic [dlcfw_pkg::LATENCY_W-1:0] age_limit,
    output dlcfw_pkg::link_status_t         status
);

    localparam int unsigned W = dlcfw_pkg::TIME_W;

    logic [W-1:0] speed_age;
    logic [W-1:0] torque_age;
    logic [W-1:0] skew;
    logic [W-1:0] speed_mag;
    logic [W-1:0] torque_mag;
    logic [W-1:0] skew_mag;
    logic [W-1:0] limit;
    logic [W-1:0] skew_limit;

    function automatic logic [W-1:0] magnitude(input logic [W-1:0] d);
        logic [W-1:0] min_neg;
        logic [W-1:0] max_pos;
        min_neg = {1'b1, {(W-1){1'b0}}};
        max_pos = {1'b0, {(W-1){1'b1}}};
        if (!d[W-1]) begin
            return d;
        end else if (d == min_neg) begin
            return max_pos;
        end else begin
            return W'(~d + W'(1));
        end
    endfunction

    assign speed_age  = now_ms - speed_stamp;
    assign torque_age = now_ms - torque_stamp;
    assign skew       = speed_stamp - torque_stamp;

    assign speed_mag  = magnitude(speed_age);
    assign torque_mag = magnitude(torque_age);
    assign skew_mag   = magnitude(skew);

    assign limit      = W'(age_limit);
    assign skew_limit = W'(age_limit >> 1);

    assign status.failed = !speed_seen || !torque_seen
                         || (speed_mag > limit) || (torque_mag > limit)
                         || (skew_mag > skew_limit);

    assign status.worst_age = (speed_age > torque_age) ? speed_age : torque_age;

endmodule

FILE: sv/dlcfw_supervisor.sv
// ----------------------------------------------------------------------------
// dlcfw_supervisor
// Run flag, source selection, measurement period and worst-age trackers.
// ----------------------------------------------------------------------------
module dlcfw_supervisor (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [dlcfw_pkg::TIME_W-1:0] now_ms,
    input  logic                         reinit_button,
    input  dlcfw_pkg::link_status_t      pri_status,
    input  dlcfw_pkg::link_status_t      aux_status,
    input  logic [dlcfw_pkg::TIME_W-1:0] worst_period,
    output dlcfw_pkg::out_word_t         result
);

    localparam int unsigned W = dlcfw_pkg::TIME_W;

    logic                   run_reg;
    logic                   run_next;
    logic [W-1:0]           period_start_reg;
    logic [W-1:0]           period_start_next;
    logic [W-1:0]           pri_worst_reg;
    logic [W-1:0]           pri_worst_next;
    logic [W-1:0]           aux_worst_reg;
    logic [W-1:0]           aux_worst_next;
    logic                   run_req;
    logic [W-1:0]           start_base;
    logic                   restart;
    logic [W-1:0]           pri_base;
    logic [W-1:0]           aux_base;
    dlcfw_pkg::source_sel_t sel;

    always_comb begin
        run_req  = run_reg || reinit_button;
        run_next = run_req;
        if (run_req && !pri_status.failed) begin
            sel = dlcfw_pkg::SEL_PRIMARY;
        end else if (run_req && !aux_status.failed) begin
            sel = dlcfw_pkg::SEL_AUX;
        end else begin
            sel      = dlcfw_pkg::SEL_COAST;
            run_next = 1'b0;
        end
    end

    always_comb begin
        start_base        = (period_start_reg == '0) ? now_ms : period_start_reg;
        restart           = (now_ms - start_base) > worst_period;
        period_start_next = restart ? now_ms : start_base;
        pri_base          = restart ? '0 : pri_worst_reg;
        aux_base          = restart ? '0 : aux_worst_reg;
        pri_worst_next    = (pri_status.worst_age > pri_base) ? pri_status.worst_age : pri_base;
        aux_worst_next    = (aux_status.worst_age > aux_base) ? aux_status.worst_age : aux_base;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg          <= 1'b0;
            period_start_reg <= '0;
            pri_worst_reg    <= '0;
            aux_worst_reg    <= '0;
        end else if (advance) begin
            run_reg          <= run_next;
            period_start_reg <= period_start_next;
            pri_worst_reg    <= pri_worst_next;
            aux_worst_reg    <= aux_worst_next;
        end
    end

    always_comb begin
        result.source_select = sel;
        result.running       = run_next;
        result.pri_failed    = pri_status.failed;
        result.aux_failed    = aux_status.failed;
        result.pri_worst_ms  = pri_worst_next;
        result.aux_worst_ms  = aux_worst_next;
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual-link command failover watchdog. Ticks are
// sent over the input channel under random idling on both sides, and every
// result is checked against an in-bench model of link timing, run flag,
// source selection and worst-age tracking, across several register settings.
// ----------------------------------------------------------------------------

class watchdog_scoreboard;
    logic [15:0] latency_limit;
    logic [31:0] window_len;
    logic        run_flag;
    logic [31:0] window_start;
    logic [31:0] pri_worst;
    logic [31:0] aux_worst;
    dlcfw_pkg::out_word_t expected_verdicts[$];
    int mismatches;
    int verdicts_checked;

    function new();
        latency_limit = dlcfw_pkg::LATENCY_RESET;
        window_len = dlcfw_pkg::PERIOD_RESET;
        run_flag = 1'b0;
        window_start = '0;
        pri_worst = '0;
        aux_worst = '0;
        mismatches = 0;
        verdicts_checked = 0;
    endfunction

    function void write_reg(logic [dlcfw_pkg::CFG_INDEX_W-1:0] index, logic [31:0] value);
        case (index)
            dlcfw_pkg::CFG_ALLOWED_LATENCY: latency_limit = value[15:0];
            dlcfw_pkg::CFG_WORST_PERIOD: window_len = value;
            default: ;
        endcase
    endfunction

    function logic [31:0] age_magnitude(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        if (d[31]) begin
            d = -d;
            if (d == 32'h8000_0000) d = 32'h7FFF_FFFF;
        end
        return d;
    endfunction

    function logic link_down(logic [31:0] now, logic speed_seen, logic torque_seen,
                             logic [31:0] speed_stamp, logic [31:0] torque_stamp);
        logic [31:0] limit;
        limit = 32'(latency_limit);
        return !speed_seen || !torque_seen
            || age_magnitude(now, speed_stamp) > limit
            || age_magnitude(now, torque_stamp) > limit
            || age_magnitude(speed_stamp, torque_stamp) > limit / 2;
    endfunction

    function logic [31:0] oldest_part(logic [31:0] now, logic [31:0] speed_stamp,
                                      logic [31:0] torque_stamp);
        logic [31:0] a;
        logic [31:0] b;
        a = now - speed_stamp;
        b = now - torque_stamp;
        return (a > b) ? a : b;
    endfunction

    function void note_tick(dlcfw_pkg::in_word_t w);
        dlcfw_pkg::out_word_t v;
        logic pri_down;
        logic aux_down;
        logic [31:0] age;
        pri_down = link_down(w.now_ms, w.pri_speed_seen, w.pri_torque_seen,
                             w.pri_speed_stamp, w.pri_torque_stamp);
        aux_down = link_down(w.now_ms, w.aux_speed_seen, w.aux_torque_seen,
                             w.aux_speed_stamp, w.aux_torque_stamp);
        if (w.reinit_button) run_flag = 1'b1;
        if (run_flag && !pri_down) begin
            v.source_select = dlcfw_pkg::SEL_PRIMARY;
        end else if (run_flag && !aux_down) begin
            v.source_select = dlcfw_pkg::SEL_AUX;
        end else begin
            run_flag = 1'b0;
            v.source_select = dlcfw_pkg::SEL_COAST;
        end
        if (window_start == '0) window_start = w.now_ms;
        if (w.now_ms - window_start > window_len) begin
            window_start = w.now_ms;
            pri_worst = '0;
            aux_worst = '0;
        end
        age = oldest_part(w.now_ms, w.pri_speed_stamp, w.pri_torque_stamp);
        if (age > pri_worst) pri_worst = age;
        age = oldest_part(w.now_ms, w.aux_speed_stamp, w.aux_torque_stamp);
        if (age > aux_worst) aux_worst = age;
        v.running = run_flag;
        v.pri_failed = pri_down;
        v.aux_failed = aux_down;
        v.pri_worst_ms = pri_worst;
        v.aux_worst_ms = aux_worst;
        expected_verdicts.push_back(v);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                         verdicts_checked, field, want, got);
        end
    endfunction

    function void check_verdict(dlcfw_pkg::out_word_t got);
        dlcfw_pkg::out_word_t want;
        if (expected_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected result with nothing pending: %h", got);
            return;
        end
        want = expected_verdicts.pop_front();
        compare_field("source_select", 32'(want.source_select), 32'(got.source_select));
        compare_field("running", 32'(want.running), 32'(got.running));
        compare_field("pri_failed", 32'(want.pri_failed), 32'(got.pri_failed));
        compare_field("aux_failed", 32'(want.aux_failed), 32'(got.aux_failed));
        compare_field("pri_worst_ms", want.pri_worst_ms, got.pri_worst_ms);
        compare_field("aux_worst_ms", want.aux_worst_ms, got.aux_worst_ms);
        verdicts_checked++;
    endfunction

    function int pending();
        return expected_verdicts.size();
    endfunction
endclass

module tb_top;
    import dlcfw_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = CFG_INDEX_W'(3);
    localparam int CYCLE_LIMIT = 500000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    watchdog_scoreboard sb;
    logic [31:0] sim_now;
    int  cycle_count;
    int  ticks_sent;
    int  settings_used;
    bit  stall_enable;
    bit  sender_quiet;
    int  stall_left;
    int  quiet_left;

    dual_link_command_failover_watchdog dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                     sb.pending());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_verdict(m_data);
    end

    always @(negedge aclk) begin
        if (!stall_enable || quiet_left > 0) begin
            if (quiet_left > 0) quiet_left--;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 15) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 40) == 0) quiet_left = $urandom_range(30, 120);
            m_ready <= 1'b1;
        end
    end

    task automatic send_tick(in_word_t w);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_tick(w);
        ticks_sent++;
    endtask

    task automatic sender_pause(int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        sender_pause(1);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(index, value);
    endtask

    task automatic set_limits(logic [15:0] latency, logic [31:0] period);
        write_reg(CFG_ALLOWED_LATENCY, 32'(latency));
        write_reg(CFG_WORST_PERIOD, period);
        settings_used++;
    endtask

    function automatic in_word_t tick_at(logic [31:0] now);
        in_word_t w;
        w = '0;
        w.now_ms = now;
        w.pri_speed_seen = 1'b1;
        w.pri_torque_seen = 1'b1;
        w.aux_speed_seen = 1'b1;
        w.aux_torque_seen = 1'b1;
        w.pri_speed_stamp = now;
        w.pri_torque_stamp = now;
        w.aux_speed_stamp = now;
        w.aux_torque_stamp = now;
        return w;
    endfunction

    function automatic logic [31:0] stamp_near(logic [31:0] now, logic [15:0] latency);
        int unsigned span;
        int unsigned pick;
        span = 32'(latency) + 32'(latency) / 2 + 2;
        pick = $urandom_range(0, 11);
        if (pick == 0) return now + $urandom_range(0, span);
        if (pick <= 2) return now - $urandom_range(0, span);
        if (pick == 3) return now - 32'(latency) - $urandom_range(0, 1);
        return now - $urandom_range(0, latency);
    endfunction

    function automatic in_word_t next_tick();
        in_word_t w;
        logic [15:0] latency;
        latency = sb.latency_limit;
        if ($urandom_range(0, 99) < 8) begin
            w.now_ms = $urandom;
            w.reinit_button = 1'($urandom_range(0, 1));
            w.pri_speed_seen = 1'($urandom_range(0, 1));
            w.pri_torque_seen = 1'($urandom_range(0, 1));
            w.pri_speed_stamp = $urandom;
            w.pri_torque_stamp = $urandom;
            w.aux_speed_seen = 1'($urandom_range(0, 1));
            w.aux_torque_seen = 1'($urandom_range(0, 1));
            w.aux_speed_stamp = $urandom;
            w.aux_torque_stamp = $urandom;
            return w;
        end
        if ($urandom_range(0, 49) == 0) sim_now += $urandom;
        else sim_now += $urandom_range(0, 25);
        w.now_ms = sim_now;
        w.reinit_button = ($urandom_range(0, 7) == 0);
        w.pri_speed_seen = ($urandom_range(0, 15) != 0);
        w.pri_torque_seen = ($urandom_range(0, 15) != 0);
        w.aux_speed_seen = ($urandom_range(0, 15) != 0);
        w.aux_torque_seen = ($urandom_range(0, 15) != 0);
        w.pri_speed_stamp = stamp_near(sim_now, latency);
        w.aux_speed_stamp = stamp_near(sim_now, latency);
        if ($urandom_range(0, 3) == 0)
            w.pri_torque_stamp = w.pri_speed_stamp - 32'(latency / 2) - $urandom_range(0, 1);
        else
            w.pri_torque_stamp = stamp_near(sim_now, latency);
        if ($urandom_range(0, 3) == 0)
            w.aux_torque_stamp = w.aux_speed_stamp + 32'(latency / 2) + $urandom_range(0, 1);
        else
            w.aux_torque_stamp = stamp_near(sim_now, latency);
        return w;
    endfunction

    task automatic run_random(int count);
        if ($urandom_range(0, 2) == 0) sim_now = 32'hFFFF_FC00 + $urandom_range(0, 512);
        else sim_now = $urandom;
        for (int i = 0; i < count; i++) begin
            if (stall_enable) begin
                if (i % 48 == 0) sender_quiet = ($urandom_range(0, 2) == 0);
                if (!sender_quiet && $urandom_range(0, 5) == 0)
                    sender_pause($urandom_range(1, 12));
            end
            send_tick(next_tick());
        end
    endtask

    task automatic run_directed();
        in_word_t t;
        logic [31:0] base;
        base = 32'd5000;
        t = '0;
        send_tick(t);
        t = tick_at(base);
        send_tick(t);
        t.reinit_button = 1'b1;
        send_tick(t);
        t = tick_at(base + 1);
        t.pri_speed_seen = 1'b0;
        send_tick(t);
        t = tick_at(base + 2);
        t.pri_torque_seen = 1'b0;
        send_tick(t);
        t = tick_at(base + 3);
        t.pri_speed_stamp = base + 3 - 100;
        t.pri_torque_stamp = base + 3 - 100;
        send_tick(t);
        t = tick_at(base + 4);
        t.pri_speed_stamp = base + 4 - 101;
        t.pri_torque_stamp = base + 4 - 101;
        send_tick(t);
        t = tick_at(base + 5);
        t.pri_speed_stamp = base + 5 - 10;
        t.pri_torque_stamp = base + 5 - 60;
        send_tick(t);
        t.pri_torque_stamp = base + 5 - 61;
        send_tick(t);
        t = tick_at(base + 6);
        t.pri_speed_stamp = base + 6 + 30;
        send_tick(t);
        t = tick_at(base + 7);
        t.aux_speed_stamp = base + 7 - 32'h8000_0000;
        send_tick(t);
        t = tick_at(base + 8);
        t.pri_torque_seen = 1'b0;
        t.aux_speed_seen = 1'b0;
        send_tick(t);
        t.reinit_button = 1'b1;
        send_tick(t);
        t = tick_at(base + 9);
        t.reinit_button = 1'b1;
        send_tick(t);
        t = tick_at(base + 1000);
        t.aux_torque_stamp = base + 900;
        send_tick(t);
        t = tick_at(base + 1001);
        send_tick(t);
        t = tick_at(32'd3);
        t.pri_speed_stamp = 32'hFFFF_FFFE;
        t.pri_torque_stamp = 32'hFFFF_FFFE;
        send_tick(t);
        t = '1;
        send_tick(t);
        t = tick_at(base + 20);
        t.pri_speed_stamp = base - 500;
        t.aux_torque_stamp = base + 20 - 50;
        send_tick(t);
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        cycle_count = 0;
        ticks_sent = 0;
        settings_used = 1;
        stall_enable = 1'b1;
        sender_quiet = 1'b0;
        stall_left = 0;
        quiet_left = 0;
        sim_now = '0;
        sb = new();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        run_random(150);
        drain();
        run_random(150);
        drain();

        set_limits(16'd0, 32'd0);
        run_random(200);
        drain();

        set_limits(16'hFFFF, 32'hFFFF_FFFF);
        run_random(250);
        drain();

        set_limits(16'd1, 32'd7);
        write_reg(CFG_UNMAPPED, $urandom);
        run_random(200);
        drain();

        set_limits(16'($urandom_range(0, 400)), $urandom_range(0, 3000));
        run_random(350);
        drain();

        stall_enable = 1'b0;
        set_limits(16'd100, 32'd1000);
        run_random(350);
        drain();
        repeat (10) @(posedge aclk);

        $display("Sent %0d ticks under %0d latency and period settings; %0d results checked.",
                 ticks_sent, settings_used, sb.verdicts_checked);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
